@@ design/jdht_pkg.sv @@
package jdht_pkg;

    localparam int BYTE_W           = 8;
    localparam int NIB_W            = 4;
    localparam int LEN_W            = 5;
    localparam int CODE_W           = 16;
    localparam int SEGLEN_W         = 16;
    localparam int KIND_W           = 2;

    localparam int MAX_CODE_LEN_DEF = 16;
    localparam int NUM_DESTS_DEF    = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_CODE      = 2'd0,
        KIND_EMPTY     = 2'd1,
        KIND_BAD_CLASS = 2'd2,
        KIND_BAD_DEST  = 2'd3
    } kind_t;

endpackage

@@ design/jdht_seg_if.sv @@
interface jdht_seg_if
    import jdht_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              seg_start;

    modport source (output valid, output in_byte, output seg_start, input ready);
    modport sink   (input valid, input in_byte, input seg_start, output ready);
endinterface

@@ design/jdht_code_if.sv @@
interface jdht_code_if
    import jdht_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [NIB_W-1:0]    table_class;
    logic [NIB_W-1:0]    table_dest;
    logic [BYTE_W-1:0]   symbol;
    logic [LEN_W-1:0]    code_length;
    logic [CODE_W-1:0]   code_word;
    logic                table_end;
    logic                segment_end;

    modport source (
        output valid, output kind, output table_class, output table_dest,
        output symbol, output code_length, output code_word,
        output table_end, output segment_end,
        input  ready
    );
    modport sink (
        input  valid, input kind, input table_class, input table_dest,
        input  symbol, input code_length, input code_word,
        input  table_end, input segment_end,
        output ready
    );
endinterface

@@ design/jdht_seek.sv @@
module jdht_seek
    import jdht_pkg::*;
#(
    parameter int WIDTH = MAX_CODE_LEN_DEF,
    parameter int IDX_W = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
    input  logic [WIDTH-1:0] mask,
    output logic             found,
    output logic [IDX_W-1:0] idx
);

    // lowest set bit wins
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                found = 1'b1;
                idx   = IDX_W'(i);
            end
        end
    end

endmodule

@@ design/jpeg_dht_parse_canonical_codes_top.sv @@
// DHT segment parser. Takes one segment byte per cycle, from the high length
// byte onwards (seg_start marks it and restarts parsing from any state), and
// gives one result per symbol value: its symbol, code length and canonical
// code, with table_end on the last one of a table and segment_end when the
// segment length is used up at that point. Empty tables give a table-done
// result; a bad class or destination gives an error result and the rest of
// the segment is dropped. A byte's result is registered and appears on the
// output in the cycle after the byte is taken; a new byte is taken every cycle
// unless the single result register holds a result the sink has not yet taken.
module jpeg_dht_parse_canonical_codes_top
    import jdht_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int NUM_DESTS    = NUM_DESTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    jdht_seg_if.sink           seg,
    jdht_code_if.source        codes
);

    localparam int IDX_W = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_LEN_LO = 5'b00010,
        PH_HEADER = 5'b00100,
        PH_COUNTS = 5'b01000,
        PH_VALUES = 5'b10000
    } phase_t;

    typedef struct packed {
        kind_t              kind;
        logic [NIB_W-1:0]   table_class;
        logic [NIB_W-1:0]   table_dest;
        logic [BYTE_W-1:0]  symbol;
        logic [LEN_W-1:0]   code_length;
        logic [CODE_W-1:0]  code_word;
        logic               table_end;
        logic               segment_end;
    } res_t;

    phase_t                phase_reg, phase_next;
    logic [SEGLEN_W-1:0]   seg_len_reg, seg_len_next;
    logic [SEGLEN_W-1:0]   used_reg, used_next, used_inc;
    logic                  class_reg, class_next;
    logic [NIB_W-1:0]      dest_reg, dest_next;
    logic [IDX_W-1:0]      ci_reg, ci_next;
    logic [BYTE_W-1:0]     left_reg, left_next, left_dec;
    logic [CODE_W-1:0]     code_reg, code_next, code_inc;
    logic [MAX_CODE_LEN-1:0] nz_reg;
    logic [BYTE_W-1:0]     counts_mem [MAX_CODE_LEN];

    logic                  out_valid_reg;
    res_t                  out_reg;
    res_t                  res;
    logic                  res_valid;

    logic                  accept;
    logic                  count_wr;
    logic [BYTE_W-1:0]     b;
    logic [NIB_W-1:0]      hi, lo;
    logic [MAX_CODE_LEN-1:0] all_mask, above_mask, seek_mask;
    logic                  seek_found;
    logic [IDX_W-1:0]      seek_idx;
    logic [BYTE_W-1:0]     count_sel;
    logic [LEN_W-1:0]      seek_end, shift_amt;
    logic                  seg_done;

    assign seg.ready = !out_valid_reg || codes.ready;
    assign accept    = seg.valid && seg.ready;
    assign b         = seg.in_byte;
    assign hi        = b[BYTE_W-1:NIB_W];
    assign lo        = b[NIB_W-1:0];

    always_comb
    begin
        for (int i = 0; i < MAX_CODE_LEN; i++)
        begin
            all_mask[i]   = (IDX_W'(i) == ci_reg) ? (b != '0) : nz_reg[i];
            above_mask[i] = nz_reg[i] && (IDX_W'(i) > ci_reg);
        end
    end

    assign seek_mask = (phase_reg == PH_COUNTS) ? all_mask : above_mask;

    jdht_seek #(
        .WIDTH (MAX_CODE_LEN),
        .IDX_W (IDX_W)
    ) u_seek (
        .mask  (seek_mask),
        .found (seek_found),
        .idx   (seek_idx)
    );

    assign count_sel = (phase_reg == PH_COUNTS && seek_idx == ci_reg) ? b
                                                                       : counts_mem[seek_idx];
    assign seek_end  = seek_found ? LEN_W'(seek_idx) : LEN_W'(MAX_CODE_LEN);
    assign shift_amt = seek_end - LEN_W'(ci_reg);
    assign used_inc  = (used_reg == {SEGLEN_W{1'b1}}) ? used_reg : used_reg + 1'b1;
    assign left_dec  = left_reg - 1'b1;
    assign code_inc  = code_reg + 1'b1;
    assign seg_done  = (used_inc >= seg_len_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        seg_len_next = seg_len_reg;
        used_next    = used_reg;
        class_next   = class_reg;
        dest_next    = dest_reg;
        ci_next      = ci_reg;
        left_next    = left_reg;
        code_next    = code_reg;
        count_wr     = 1'b0;
        res_valid    = 1'b0;
        res          = '{kind: KIND_CODE, table_class: {{(NIB_W-1){1'b0}}, class_reg},
                         table_dest: dest_reg, symbol: '0, code_length: '0,
                         code_word: '0, table_end: 1'b0, segment_end: 1'b0};

        if (accept)
        begin
            if (seg.seg_start)
            begin
                seg_len_next = {b, {(SEGLEN_W-BYTE_W){1'b0}}};
                used_next    = SEGLEN_W'(1);
                phase_next   = PH_LEN_LO;
            end
            else if (phase_reg != PH_IDLE)
            begin
                used_next = used_inc;
                unique case (phase_reg)
                    PH_LEN_LO:
                    begin
                        seg_len_next = {seg_len_reg[SEGLEN_W-1:BYTE_W], b};
                        phase_next   = (used_inc >= seg_len_next) ? PH_IDLE : PH_HEADER;
                    end
                    PH_HEADER:
                    begin
                        res.table_class = hi;
                        res.table_dest  = lo;
                        res.table_end   = 1'b1;
                        res.segment_end = 1'b1;
                        if (hi > NIB_W'(1))
                        begin
                            res.kind   = KIND_BAD_CLASS;
                            res_valid  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else if ({1'b0, lo} >= (NIB_W+1)'(NUM_DESTS))
                        begin
                            res.kind   = KIND_BAD_DEST;
                            res_valid  = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            class_next = hi[0];
                            dest_next  = lo;
                            ci_next    = '0;
                            phase_next = PH_COUNTS;
                        end
                    end
                    PH_COUNTS:
                    begin
                        count_wr = 1'b1;
                        if (ci_reg == IDX_W'(MAX_CODE_LEN - 1))
                        begin
                            code_next = '0;
                            if (!seek_found)
                            begin
                                res.kind        = KIND_EMPTY;
                                res.table_end   = 1'b1;
                                res.segment_end = seg_done;
                                res_valid       = 1'b1;
                                phase_next      = seg_done ? PH_IDLE : PH_HEADER;
                            end
                            else
                            begin
                                ci_next    = seek_idx;
                                left_next  = count_sel;
                                phase_next = PH_VALUES;
                            end
                        end
                        else
                        begin
                            ci_next = ci_reg + 1'b1;
                        end
                    end
                    PH_VALUES:
                    begin
                        res.kind        = KIND_CODE;
                        res.symbol      = b;
                        res.code_length = LEN_W'(ci_reg) + LEN_W'(1);
                        res.code_word   = code_reg;
                        res_valid       = 1'b1;
                        if (left_dec == '0)
                        begin
                            code_next = code_inc << shift_amt;
                            if (!seek_found)
                            begin
                                res.table_end   = 1'b1;
                                res.segment_end = seg_done;
                                phase_next      = seg_done ? PH_IDLE : PH_HEADER;
                            end
                            else
                            begin
                                ci_next   = seek_idx;
                                left_next = count_sel;
                            end
                        end
                        else
                        begin
                            code_next = code_inc;
                            left_next = left_dec;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            seg_len_reg   <= '0;
            used_reg      <= '0;
            class_reg     <= 1'b0;
            dest_reg      <= '0;
            ci_reg        <= '0;
            left_reg      <= '0;
            code_reg      <= '0;
            nz_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            seg_len_reg <= seg_len_next;
            used_reg    <= used_next;
            class_reg   <= class_next;
            dest_reg    <= dest_next;
            ci_reg      <= ci_next;
            left_reg    <= left_next;
            code_reg    <= code_next;
            if (count_wr)
            begin
                nz_reg[ci_reg] <= (b != '0);
            end
            if (seg.ready)
            begin
                out_valid_reg <= accept && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (count_wr)
        begin
            counts_mem[ci_reg] <= b;
        end
        if (accept && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign codes.valid       = out_valid_reg;
    assign codes.kind        = out_reg.kind;
    assign codes.table_class = out_reg.table_class;
    assign codes.table_dest  = out_reg.table_dest;
    assign codes.symbol      = out_reg.symbol;
    assign codes.code_length = out_reg.code_length;
    assign codes.code_word   = out_reg.code_word;
    assign codes.table_end   = out_reg.table_end;
    assign codes.segment_end = out_reg.segment_end;

endmodule

@@ verif/jdht_code_checker.sv @@
module jdht_code_checker
    import jdht_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int NUM_DESTS    = NUM_DESTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    jdht_seg_if  seg,
    jdht_code_if codes,
    output int   fails,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_LEN_LO,
        PS_HEADER,
        PS_COUNTS,
        PS_VALUES
    } parse_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [NIB_W-1:0]   table_class;
        logic [NIB_W-1:0]   table_dest;
        logic [BYTE_W-1:0]  symbol;
        logic [LEN_W-1:0]   code_length;
        logic [CODE_W-1:0]  code_word;
        logic               table_end;
        logic               segment_end;
    } code_entry_t;

    parse_state_t         pstate;
    logic [SEGLEN_W-1:0]  seg_len;
    logic [SEGLEN_W-1:0]  used;
    logic                 cur_cls;
    logic [1:0]           cur_dst;
    logic [7:0]           len_cnt [16];
    logic [4:0]           len_idx;
    logic [7:0]           left;
    logic [CODE_W-1:0]    nxt_code;

    code_entry_t          expected_codes [$];
    int                   n_fail = 0;
    int                   n_wait = 0;

    assign fails   = n_fail;
    assign pending = n_wait;

    function automatic logic close_table();
        logic done;
        done   = (used >= seg_len);
        pstate = done ? PS_IDLE : PS_HEADER;
        return done;
    endfunction

    function automatic logic predict_code(input logic [7:0] b, input logic s,
                                          output code_entry_t r);
        int j;
        r = '0;
        if (s)
        begin
            seg_len = {b, 8'h00};
            used    = 16'd1;
            pstate  = PS_LEN_LO;
            return 1'b0;
        end
        if (pstate == PS_IDLE)
            return 1'b0;
        if (used != 16'hFFFF)
            used = used + 1'b1;

        case (pstate)
            PS_LEN_LO:
            begin
                seg_len[7:0] = b;
                pstate = (used >= seg_len) ? PS_IDLE : PS_HEADER;
                return 1'b0;
            end
            PS_HEADER:
            begin
                if (b[7:4] > 4'd1 || b[3:0] >= NUM_DESTS)
                begin
                    r.kind        = (b[7:4] > 4'd1) ? KIND_BAD_CLASS : KIND_BAD_DEST;
                    r.table_class = b[7:4];
                    r.table_dest  = b[3:0];
                    r.table_end   = 1'b1;
                    r.segment_end = 1'b1;
                    pstate = PS_IDLE;
                    return 1'b1;
                end
                cur_cls = b[4];
                cur_dst = b[1:0];
                len_idx = '0;
                pstate  = PS_COUNTS;
                return 1'b0;
            end
            PS_COUNTS:
            begin
                len_cnt[len_idx[3:0]] = b;
                len_idx = len_idx + 1'b1;
                if (len_idx < MAX_CODE_LEN)
                    return 1'b0;
                nxt_code = '0;
                j = 0;
                while (j < MAX_CODE_LEN && len_cnt[j] == 0)
                    j++;
                if (j >= MAX_CODE_LEN)
                begin
                    r.kind        = KIND_EMPTY;
                    r.table_class = {3'b000, cur_cls};
                    r.table_dest  = {2'b00, cur_dst};
                    r.table_end   = 1'b1;
                    r.segment_end = close_table();
                    return 1'b1;
                end
                len_idx = j[4:0];
                left    = len_cnt[j];
                pstate  = PS_VALUES;
                return 1'b0;
            end
            PS_VALUES:
            begin
                r.kind        = KIND_CODE;
                r.table_class = {3'b000, cur_cls};
                r.table_dest  = {2'b00, cur_dst};
                r.symbol      = b;
                r.code_length = {1'b0, len_idx[3:0]} + 5'd1;
                r.code_word   = nxt_code;
                nxt_code = nxt_code + 1'b1;
                left     = left - 1'b1;
                if (left == 0)
                begin
                    j = len_idx[3:0] + 1;
                    nxt_code = nxt_code << 1;
                    while (j < MAX_CODE_LEN && len_cnt[j] == 0)
                    begin
                        nxt_code = nxt_code << 1;
                        j++;
                    end
                    if (j >= MAX_CODE_LEN)
                    begin
                        r.table_end   = 1'b1;
                        r.segment_end = close_table();
                    end
                    else
                    begin
                        len_idx = j[4:0];
                        left    = len_cnt[j];
                    end
                end
                return 1'b1;
            end
            default:
            begin
                pstate = PS_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        code_entry_t want;
        code_entry_t got;
        code_entry_t next_entry;
        if (!rst_n)
        begin
            pstate   = PS_IDLE;
            seg_len  = '0;
            used     = '0;
            cur_cls  = 1'b0;
            cur_dst  = '0;
            len_idx  = '0;
            left     = '0;
            nxt_code = '0;
            foreach (len_cnt[i])
                len_cnt[i] = '0;
            expected_codes.delete();
            n_wait = 0;
        end
        else
        begin
            if (codes.valid && codes.ready)
            begin
                got.kind        = kind_t'(codes.kind);
                got.table_class = codes.table_class;
                got.table_dest  = codes.table_dest;
                got.symbol      = codes.symbol;
                got.code_length = codes.code_length;
                got.code_word   = codes.code_word;
                got.table_end   = codes.table_end;
                got.segment_end = codes.segment_end;
                if (expected_codes.size() == 0)
                begin
                    $error("unexpected result: kind %0d symbol %0h code %0h",
                           got.kind, got.symbol, got.code_word);
                    n_fail++;
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, got.kind);
                        n_fail++;
                    end
                    if (got.table_class !== want.table_class)
                    begin
                        $error("table_class: expected %0h, got %0h",
                               want.table_class, got.table_class);
                        n_fail++;
                    end
                    if (got.table_dest !== want.table_dest)
                    begin
                        $error("table_dest: expected %0h, got %0h",
                               want.table_dest, got.table_dest);
                        n_fail++;
                    end
                    if (got.symbol !== want.symbol)
                    begin
                        $error("symbol: expected %0h, got %0h", want.symbol, got.symbol);
                        n_fail++;
                    end
                    if (got.code_length !== want.code_length)
                    begin
                        $error("code_length: expected %0d, got %0d",
                               want.code_length, got.code_length);
                        n_fail++;
                    end
                    if (got.code_word !== want.code_word)
                    begin
                        $error("code_word: expected %0h, got %0h",
                               want.code_word, got.code_word);
                        n_fail++;
                    end
                    if (got.table_end !== want.table_end)
                    begin
                        $error("table_end: expected %0b, got %0b",
                               want.table_end, got.table_end);
                        n_fail++;
                    end
                    if (got.segment_end !== want.segment_end)
                    begin
                        $error("segment_end: expected %0b, got %0b",
                               want.segment_end, got.segment_end);
                        n_fail++;
                    end
                end
            end
            if (seg.valid && seg.ready)
            begin
                if (predict_code(seg.in_byte, seg.seg_start, next_entry))
                    expected_codes.push_back(next_entry);
            end
            n_wait = expected_codes.size();
        end
    end

endmodule

@@ verif/tb_jpeg_dht_parse_canonical_codes_top.sv @@
module tb_jpeg_dht_parse_canonical_codes_top;
    import jdht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 217;

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle;
    int   recv_idle;
    bit   hold_go = 1'b0;
    int   sent_items = 0;
    int   idle_cycles = 0;
    int   fails;
    int   pending;

    jdht_seg_if  seg_ch ();
    jdht_code_if code_ch ();

    jpeg_dht_parse_canonical_codes_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .seg   (seg_ch),
        .codes (code_ch)
    );

    jdht_code_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .seg     (seg_ch),
        .codes   (code_ch),
        .fails   (fails),
        .pending (pending)
    );

    always #10 clk = ~clk;

    initial
    begin
        code_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                code_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_go = 1'b0;
            end
            else
                code_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((seg_ch.valid && seg_ch.ready) || (code_ch.valid && code_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("jpeg_dht_parse_canonical_codes_top: mismatch");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_byte(input logic [7:0] b, input logic s);
        while ($urandom_range(99) < send_idle)
        begin
            seg_ch.valid <= 1'b0;
            @(negedge clk);
        end
        seg_ch.valid     <= 1'b1;
        seg_ch.in_byte   <= b;
        seg_ch.seg_start <= s;
        do
            @(posedge clk);
        while (!seg_ch.ready);
        @(negedge clk);
    endtask

    task automatic drain();
        seg_ch.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
    endtask

    task automatic send_random_segment(input bit well_formed);
        logic [7:0]  body [$];
        logic [7:0]  cnt [16];
        logic [15:0] seg_len;
        int          ntab;
        int          shape;
        int          nsym;
        int          total;
        int          pick;
        ntab = $urandom_range(1, 3);
        for (int t = 0; t < ntab; t++)
        begin
            shape = well_formed ? $urandom_range(22, 94) : $urandom_range(99);
            if (shape < 6)
                body.push_back(8'($urandom_range(8'h20, 8'hFF)));
            else if (shape < 12)
                body.push_back({3'b000, 1'($urandom_range(1)), 4'($urandom_range(4, 15))});
            else
                body.push_back({3'b000, 1'($urandom_range(1)), 2'b00, 2'($urandom_range(3))});
            foreach (cnt[i])
                cnt[i] = '0;
            if (shape >= 22)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    pick = $urandom_range(15);
                    cnt[pick] = cnt[pick] + 8'($urandom_range(1, 4));
                end
                if (shape >= 95)
                    cnt[$urandom_range(15)] = 8'($urandom_range(20, 60));
            end
            nsym = 0;
            foreach (cnt[i])
            begin
                body.push_back(cnt[i]);
                nsym += cnt[i];
            end
            repeat (nsym)
                body.push_back(8'($urandom));
        end

        total = body.size() + 2;
        pick  = well_formed ? 0 : $urandom_range(99);
        if (pick < 70)
            seg_len = 16'(total);
        else if (pick < 78)
            seg_len = 16'($urandom_range(0, 2));
        else if (pick < 90)
            seg_len = 16'($urandom_range(3, total));
        else
            seg_len = 16'($urandom);
        // broken segment: cut short, the next start restarts the parser
        if (!well_formed && $urandom_range(99) < 10)
            body = body[0:$urandom_range(body.size() - 1)];

        send_byte(seg_len[15:8], 1'b1);
        send_byte(seg_len[7:0], 1'b0);
        foreach (body[i])
            send_byte(body[i], 1'b0);
        sent_items += body.size() + 2;

        if (!well_formed && $urandom_range(99) < 8)
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom), 1'b0);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        seg_ch.valid     = 1'b0;
        seg_ch.in_byte   = '0;
        seg_ch.seg_start = 1'b0;
        send_idle        = 36;
        recv_idle        = 61;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stray byte before any segment
        send_byte(8'hFF, 1'b0);
        // length of two: segment over at once
        send_byte(8'h00, 1'b1);
        send_byte(8'h02, 1'b0);
        // bad class, trailing byte dropped
        send_byte(8'h00, 1'b1);
        send_byte(8'h05, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h00, 1'b0);
        // bad destination
        send_byte(8'h00, 1'b1);
        send_byte(8'h05, 1'b0);
        send_byte(8'h1F, 1'b0);
        // empty table filling the segment exactly
        send_byte(8'h00, 1'b1);
        send_byte(8'h13, 1'b0);
        send_byte(8'h13, 1'b0);
        repeat (16) send_byte(8'h00, 1'b0);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 36 : (ph == 1) ? 61 : 0;
            recv_idle = (ph == 0) ? 61 : (ph == 1) ? 36 : 0;
            if (ph == 2)
            begin
                hold_go = 1'b1;
                send_random_segment(1'b1);
            end
            while (sent_items < (ph + 1) * ITEMS_PER_PHASE)
                send_random_segment(1'b0);
            drain();
        end

        seg_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(posedge clk);
        if (fails == 0)
            $display("jpeg_dht_parse_canonical_codes_top: match");
        else
            $display("jpeg_dht_parse_canonical_codes_top: mismatch");
        $finish;
    end

endmodule
